### sv/stsp_pkg.sv
`default_nettype none

package stsp_pkg;

    localparam int NEURONS   = 1024;
    localparam int FRAC_BITS = 23;

    localparam int DATA_W    = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int IDX_W     = 10;
    localparam int ADDR_W    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int CNT_W     = $clog2(NEURONS + 1);
    localparam int CFG_IDX_W = 3;

    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;

    localparam logic [DATA_W-1:0] ONE               = DATA_W'(ONE_L);
    localparam logic [DATA_W-1:0] RESET_DEPRESSION  = DATA_W'((ONE_L + 1000) / 2000);
    localparam logic [DATA_W-1:0] RESET_FACILITATION = DATA_W'((ONE_L + 5000) / 10000);
    localparam logic [DATA_W-1:0] RESET_POINT_TWO   = DATA_W'((2 * ONE_L + 5) / 10);

    localparam logic KIND_SPIKE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DEPRESSION_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACILITATION_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTING_USE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USE_JUMP          = 3'd3;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] neuron_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  spike_neuron;
        logic [DATA_W-1:0] release_amount;
    } out_item_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              mul_en;
        logic              tick;
        logic              wr_en;
        logic              wr_clear;
        logic [ADDR_W-1:0] wr_addr;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/short_term_synaptic_plasticity_unit.sv
// Short-term plasticity unit keeping resource x and use u for every neuron in Q1.23. A spike
// transaction reads the neuron's entry from the two state RAMs, passes it through the pair of
// shared 24x24 multipliers, then writes it back and loads the result register; the next
// transaction is taken in the cycle after the write-back. A tick streams all neurons through
// the same read, multiply and write pipeline at one neuron per cycle, with no result. After
// reset the unit writes x = 1.0 and u = 0.2 into every entry of the state RAMs and accepts no
// item meanwhile; configuration writes are always accepted, and values above 1.0 are held at
// 1.0. A result waiting in the output register does not block a new transaction; only the
// write-back of a later spike waits for it.
`default_nettype none

module short_term_synaptic_plasticity_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  stsp_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output stsp_pkg::out_item_t            m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [stsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stsp_pkg::DATA_W-1:0]    cfg_data
);

    import stsp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    stsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .status  (status),
        .cmd     (cmd)
    );

    stsp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

### sv/stsp_ram.sv
`default_nettype none

module stsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/stsp_ctrl.sv
`default_nettype none

module stsp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  stsp_pkg::in_item_t   s_item,
    input  stsp_pkg::dp_status_t status,
    output stsp_pkg::dp_cmd_t    cmd
);

    import stsp_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPIKE,
        ST_SWEEP
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [ADDR_W-1:0] addr1_reg, addr1_next;
    logic [ADDR_W-1:0] addr2_reg, addr2_next;

    logic              accept;
    logic              in_range;
    logic              stall;
    logic              issue;
    logic [ADDR_W-1:0] issue_addr;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_item.neuron_index) < NEURONS);
    // A finished spike waits in the last stage until the output register frees up.
    assign stall    = v2_reg && (state_reg == ST_SPIKE) && !status.out_free;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        issue      = 1'b0;
        issue_addr = cnt_reg[ADDR_W-1:0];

        cmd          = '0;
        cmd.tick     = (state_reg == ST_SWEEP);
        cmd.mul_en   = v1_reg;
        cmd.wr_en    = v2_reg && !stall;
        cmd.wr_addr  = addr2_reg;
        cmd.out_load = v2_reg && (state_reg == ST_SPIKE) && !stall;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_clear = 1'b1;
                cmd.wr_addr  = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == CNT_W'(NEURONS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_item.kind == KIND_TICK) begin
                        cnt_next   = '0;
                        state_next = ST_SWEEP;
                    end else if (in_range) begin
                        issue      = 1'b1;
                        issue_addr = ADDR_W'(s_item.neuron_index);
                        state_next = ST_SPIKE;
                    end
                end
            end
            ST_SPIKE: begin
                if (v2_reg && !stall) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (cnt_reg != CNT_W'(NEURONS)) begin
                    issue      = 1'b1;
                    issue_addr = cnt_reg[ADDR_W-1:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                end else if (v2_reg && !v1_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        cmd.rd_en   = issue;
        cmd.rd_addr = issue_addr;

        if (stall) begin
            v1_next    = v1_reg;
            addr1_next = addr1_reg;
            v2_next    = v2_reg;
            addr2_next = addr2_reg;
        end else begin
            v1_next    = issue;
            addr1_next = issue_addr;
            v2_next    = v1_reg;
            addr2_next = addr1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
        addr1_reg <= addr1_next;
        addr2_reg <= addr2_next;
    end

endmodule

`default_nettype wire

### sv/stsp_datapath.sv
`default_nettype none

module stsp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  stsp_pkg::dp_cmd_t                   cmd,
    output stsp_pkg::dp_status_t                status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stsp_pkg::DATA_W-1:0]         cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output stsp_pkg::out_item_t                 m_item
);

    import stsp_pkg::*;

    logic [DATA_W-1:0] depression_rate_reg;
    logic [DATA_W-1:0] facilitation_rate_reg;
    logic [DATA_W-1:0] resting_use_reg;
    logic [DATA_W-1:0] use_jump_reg;
    logic [DATA_W-1:0] cfg_clamped;

    logic [DATA_W-1:0] x_rd, u_rd;
    logic [DATA_W-1:0] x_wdata, u_wdata;

    logic [DATA_W-1:0] mul_a, mul_b, mul_c, mul_d;
    logic [PROD_W-1:0] prod_ab, prod_cd;
    logic              rest_above;

    logic [DATA_W-1:0] pa_reg, pb_reg;
    logic [DATA_W-1:0] x_s_reg, u_s_reg;
    logic              tick_s_reg;
    logic              up_s_reg;

    logic [DATA_W-1:0] x_new, u_new;

    logic              m_valid_reg;
    out_item_t         m_item_reg;

    stsp_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_resource_ram (
        .clk   (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (x_wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (x_rd)
    );

    stsp_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_use_ram (
        .clk   (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (u_wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (u_rd)
    );

    assign cfg_ready   = 1'b1;
    assign cfg_clamped = (cfg_data > ONE) ? ONE : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depression_rate_reg   <= RESET_DEPRESSION;
            facilitation_rate_reg <= RESET_FACILITATION;
            resting_use_reg       <= RESET_POINT_TWO;
            use_jump_reg          <= RESET_POINT_TWO;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEPRESSION_RATE:   depression_rate_reg   <= cfg_clamped;
                REG_FACILITATION_RATE: facilitation_rate_reg <= cfg_clamped;
                REG_RESTING_USE:       resting_use_reg       <= cfg_clamped;
                REG_USE_JUMP:          use_jump_reg          <= cfg_clamped;
                default: begin
                end
            endcase
        end
    end

    // Both multipliers are shared between the spike update and the relaxation sweep.
    assign rest_above = (resting_use_reg >= u_rd);

    always_comb begin
        if (cmd.tick) begin
            mul_a = depression_rate_reg;
            mul_b = ONE - x_rd;
            mul_c = facilitation_rate_reg;
            mul_d = rest_above ? (resting_use_reg - u_rd) : (u_rd - resting_use_reg);
        end else begin
            mul_a = x_rd;
            mul_b = u_rd;
            mul_c = use_jump_reg;
            mul_d = ONE - u_rd;
        end
    end

    assign prod_ab = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_cd = PROD_W'(mul_c) * PROD_W'(mul_d);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            pa_reg     <= prod_ab[FRAC_BITS+DATA_W-1:FRAC_BITS];
            pb_reg     <= prod_cd[FRAC_BITS+DATA_W-1:FRAC_BITS];
            x_s_reg    <= x_rd;
            u_s_reg    <= u_rd;
            tick_s_reg <= cmd.tick;
            up_s_reg   <= rest_above;
        end
    end

    // Every product is at most the distance to its bound, so no result leaves 0..1.
    always_comb begin
        if (tick_s_reg) begin
            x_new = x_s_reg + pa_reg;
            u_new = up_s_reg ? (u_s_reg + pb_reg) : (u_s_reg - pb_reg);
        end else begin
            x_new = x_s_reg - pa_reg;
            u_new = u_s_reg + pb_reg;
        end
    end

    assign x_wdata = cmd.wr_clear ? ONE : x_new;
    assign u_wdata = cmd.wr_clear ? RESET_POINT_TWO : u_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_item_reg.spike_neuron   <= IDX_W'(cmd.wr_addr);
            m_item_reg.release_amount <= pa_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_item          = m_item_reg;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

### sv/stsp_checker.sv
`default_nettype none

module stsp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input stsp_pkg::in_item_t             s_item,
    input logic                           m_valid,
    input logic                           m_ready,
    input stsp_pkg::out_item_t            m_item,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [stsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [stsp_pkg::DATA_W-1:0]    cfg_data
);

    import stsp_pkg::*;

    // A stalled result must hold its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // The state RAMs are being cleared right after reset, so no item is taken.
    assert property (@(posedge aclk) !aresetn |=> !s_ready && !m_valid)
        else $error("unit ready or result pending right after reset");

    // A tick starts a sweep that blocks the input for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_item.kind == KIND_TICK) |=> !s_ready)
        else $error("input accepted during a relaxation sweep");

    // A release never exceeds the product of two values bounded by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.release_amount <= ONE))
        else $error("release amount above one");

    // A fresh result appears only in the cycle after the unit was busy with a spike.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a spike in flight");

endmodule

bind short_term_synaptic_plasticity_unit stsp_checker u_stsp_checker (.*);

`default_nettype wire
